@@ sv/vcu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vcu_pkg;

  typedef enum logic [1:0] {
    REQ_INC  = 2'd0,
    REQ_CMP  = 2'd1,
    REQ_JOIN = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic has_result;
  } status_t;

endpackage
`default_nettype wire

@@ sv/vector_clock_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One vector clock of MAX_THREADS entries, each a TIME_BITS timestamp with a
// present bit, cleared at reset. Requests increment or join one entry, or
// stream another clock's entries for comparison; the request marked last in a
// compare stream returns happens-before, happens-after and equality. Each
// request first reads its entry from the timestamp memory (registered read
// port) and then updates the entry and the stream counters. The result sits
// in an output register, so a new request is taken while a result waits; a
// final compare request holds in its update cycle only while an earlier
// result is still stalled.
module vector_clock_unit #(
  parameter int MAX_THREADS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  thread_index,
  input  wire logic [31:0] entry_time,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             happens_before,
  output logic             happens_after,
  output logic             clocks_equal
);
  import vcu_pkg::*;

  cmd_t    cmd;
  status_t status;

  vcu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  vcu_dp #(
    .MAX_THREADS (MAX_THREADS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req_type),
    .thread_index   (thread_index),
    .entry_time     (entry_time),
    .last           (last),
    .happens_before (happens_before),
    .happens_after  (happens_after),
    .clocks_equal   (clocks_equal)
  );

endmodule
`default_nettype wire

@@ sv/vcu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vcu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire vcu_pkg::status_t status,
  output vcu_pkg::cmd_t        cmd
);
  import vcu_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   can_finish;

  assign in_stall   = (state != S_IDLE);
  assign can_finish = !status.has_result || !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_finish) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec && status.has_result) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_exec_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.exec))
    else $error("load and exec issued together");

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC))
    else $error("load not followed by exec state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && cmd.exec) |-> !status.has_result)
    else $error("pending result overwritten");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && status.has_result) |=> out_valid)
    else $error("result not presented");

endmodule
`default_nettype wire

@@ sv/vcu_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module vcu_dp #(
  parameter int MAX_THREADS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire vcu_pkg::cmd_t cmd,
  output vcu_pkg::status_t  status,
  input  wire logic [1:0]   req_type,
  input  wire logic [3:0]   thread_index,
  input  wire logic [31:0]  entry_time,
  input  wire logic         last,
  output logic              happens_before,
  output logic              happens_after,
  output logic              clocks_equal
);
  import vcu_pkg::*;

  localparam int IDX_W     = $clog2(MAX_THREADS);
  localparam int MEM_DEPTH = 1 << IDX_W;
  localparam int CMP_W     = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
  localparam int CNT_W     = $clog2(2 * MAX_THREADS);
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(2 * MAX_THREADS - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [TIME_BITS-1:0] clock_mem [MEM_DEPTH];
  logic [MAX_THREADS-1:0] present_bits;
  logic [CNT_W-1:0] local_count;
  logic [CNT_W-1:0] seen_count;
  logic [CNT_W-1:0] covered_count;
  logic after_ok;
  logic equal_ok;

  logic [1:0]           q_type;
  logic                 q_valid;
  logic [IDX_W-1:0]     q_idx;
  logic [TIME_BITS-1:0] q_time;
  logic                 q_last;
  logic [TIME_BITS-1:0] rd_time;

  logic [CMP_W-1:0]     tid_ext;
  logic [63:0]          time_wide;
  logic                 in_range;
  logic                 pres;

  logic                 wr_en;
  logic [TIME_BITS-1:0] wr_data;
  logic                 set_present;
  logic [CNT_W-1:0]     seen_count_next;
  logic [CNT_W-1:0]     covered_count_next;
  logic                 after_ok_next;
  logic                 equal_ok_next;

  assign tid_ext   = CMP_W'(thread_index);
  assign in_range  = (tid_ext < CMP_W'(MAX_THREADS));
  assign time_wide = {32'b0, entry_time};
  assign pres      = q_valid && present_bits[q_idx];

  assign status.has_result = (q_type == REQ_CMP) && q_last;

  always_comb begin
    wr_en              = 1'b0;
    wr_data            = rd_time;
    set_present        = 1'b0;
    seen_count_next    = seen_count;
    covered_count_next = covered_count;
    after_ok_next      = after_ok;
    equal_ok_next      = equal_ok;
    case (q_type)
      REQ_INC: begin
        if (q_valid) begin
          if (!pres) begin
            wr_en       = 1'b1;
            wr_data     = TIME_BITS'(1);
            set_present = 1'b1;
          end else if (rd_time != TIME_MAX) begin
            wr_en   = 1'b1;
            wr_data = rd_time + TIME_BITS'(1);
          end
        end
      end
      REQ_JOIN: begin
        if (q_valid) begin
          if (!pres) begin
            wr_en       = 1'b1;
            wr_data     = q_time;
            set_present = 1'b1;
          end else if (q_time > rd_time) begin
            wr_en   = 1'b1;
            wr_data = q_time;
          end
        end
      end
      REQ_CMP: begin
        if (seen_count < COUNT_MAX) begin
          seen_count_next = seen_count + CNT_W'(1);
        end
        if (pres) begin
          if (q_time >= rd_time && covered_count < COUNT_MAX) begin
            covered_count_next = covered_count + CNT_W'(1);
          end
          if (rd_time < q_time) begin
            after_ok_next = 1'b0;
          end
          if (rd_time != q_time) begin
            equal_ok_next = 1'b0;
          end
        end else begin
          after_ok_next = 1'b0;
          equal_ok_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_type  <= req_type;
      q_valid <= in_range;
      q_idx   <= tid_ext[IDX_W-1:0];
      q_time  <= time_wide[TIME_BITS-1:0];
      q_last  <= last;
      rd_time <= clock_mem[tid_ext[IDX_W-1:0]];
    end
    if (cmd.exec && wr_en) begin
      clock_mem[q_idx] <= wr_data;
    end
    if (cmd.exec && status.has_result) begin
      happens_before <= (covered_count_next == local_count);
      happens_after  <= after_ok_next;
      clocks_equal   <= equal_ok_next && (seen_count_next == local_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_bits  <= '0;
      local_count   <= '0;
      seen_count    <= '0;
      covered_count <= '0;
      after_ok      <= 1'b1;
      equal_ok      <= 1'b1;
    end else if (cmd.exec) begin
      if (set_present) begin
        present_bits[q_idx] <= 1'b1;
        local_count         <= local_count + CNT_W'(1);
      end
      if (status.has_result) begin
        seen_count    <= '0;
        covered_count <= '0;
        after_ok      <= 1'b1;
        equal_ok      <= 1'b1;
      end else begin
        seen_count    <= seen_count_next;
        covered_count <= covered_count_next;
        after_ok      <= after_ok_next;
        equal_ok      <= equal_ok_next;
      end
    end
  end

endmodule
`default_nettype wire
